// File: rtl/dfr_pkg.sv
// Shared constants and types for the two-byte delimited packet deframer.
// No dependencies; the deframer top level and the testbench refer to this package by scoped names.
package dfr_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int MAXP_W       = 9;
    localparam int LEN_W        = (IDX_W > MAXP_W) ? IDX_W : MAXP_W;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD    = 3'd4;

    localparam logic [7:0]        RST_HEADER_FIRST   = 8'd67;
    localparam logic [7:0]        RST_HEADER_SECOND  = 8'd77;
    localparam logic [7:0]        RST_TRAILER_FIRST  = 8'd13;
    localparam logic [7:0]        RST_TRAILER_SECOND = 8'd10;
    localparam logic [MAXP_W-1:0] RST_MAX_PAYLOAD    = 9'd256;

    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Result of one transaction while its buffer read is in flight.
    typedef struct packed {
        logic       is_read;
        logic       packet_done;
        logic [7:0] payload_length;
    } stage_meta_t;

endpackage

// File: rtl/dfr_item_if.sv
// Input channel of the deframer: valid/ready handshake with one item.
// Depends on nothing.
interface dfr_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, action, rx_byte, read_index, input ready);
    modport sink   (input valid, action, rx_byte, read_index, output ready);
endinterface

// File: rtl/dfr_result_if.sv
// Output channel of the deframer: valid/ready handshake with one result.
// Depends on nothing.
interface dfr_result_if;
    logic       valid;
    logic       ready;
    logic       packet_done;
    logic [7:0] payload_length;
    logic [7:0] read_data;

    modport source (output valid, packet_done, payload_length, read_data, input ready);
    modport sink   (input valid, packet_done, payload_length, read_data, output ready);
endinterface

// File: rtl/dfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/two_byte_delimited_packet_deframer.sv
// Two-byte delimited packet deframer, top level.
// Depends on dfr_pkg, dfr_item_if, dfr_result_if and dfr_ram.
// Usage:
//   item   : one transaction per byte. action 0 stores rx_byte in the payload
//            buffer and runs header/trailer detection; action 1 reads the
//            buffer at read_index.
//   result : exactly one transaction per item, in order. packet_done and
//            payload_length report a completed trailer; read_data carries
//            the buffer byte of a read item.
//   cfg    : cfg_wr_en/cfg_addr/cfg_wdata write the header, trailer and
//            max_payload registers; write only while the block is idle.
// An accepted item passes the read stage (the registered read of the buffer
// RAM) and then the output register before its result is valid.
// Throughput is one item per cycle unless the receiver stalls; the single
// buffer RAM sees one access per item (a write or a read), and the previous
// byte is kept in a register so header/trailer matching needs no second read.
// Reset clears the index, the hunt state and the pipeline and loads the
// register defaults; the buffer keeps whatever it holds, no clearing pass.
// When the receiver stalls, the output register holds its result and the read
// stage still takes one more item if it is empty; after that item ready drops.
module two_byte_delimited_packet_deframer (
    input  logic                           clk,
    input  logic                           rst_n,
    dfr_item_if.sink                       item,
    dfr_result_if.source                   result,
    input  logic                           cfg_wr_en,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [7:0]                 header_first_reg;
    logic [7:0]                 header_second_reg;
    logic [7:0]                 trailer_first_reg;
    logic [7:0]                 trailer_second_reg;
    logic [dfr_pkg::MAXP_W-1:0] max_payload_reg;

    // framing state
    logic [dfr_pkg::IDX_W-1:0]  write_index_reg, write_index_next;
    logic                       in_packet_reg, in_packet_next;
    logic [7:0]                 prev_byte_reg;

    // pipeline
    logic                       s1_valid_reg, s1_valid_next;
    dfr_pkg::stage_meta_t       s1_meta_reg, s1_meta_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_done_reg;
    logic [7:0]                 out_len_reg;
    logic [7:0]                 out_data_reg;

    logic                       accept;
    logic                       s1_advance;
    logic                       rx_accept;
    logic                       rd_accept;
    logic                       buf_full;
    logic [dfr_pkg::ADDR_W-1:0] waddr;
    logic [dfr_pkg::IDX_W-1:0]  wi_bump;
    logic                       in_pkt_bump;
    logic                       pair_ok;
    logic                       hdr_hit;
    logic                       trl_hit;
    logic [dfr_pkg::LEN_W-1:0]  raw_len;
    logic [dfr_pkg::LEN_W-1:0]  clamp_len;
    logic [7:0]                 ram_q;
    logic                       rd_in_range;

    assign s1_advance = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s1_advance;
    assign accept     = item.valid && item.ready;
    assign rx_accept  = accept && (item.action == dfr_pkg::ACT_RX);
    assign rd_accept  = accept && (item.action == dfr_pkg::ACT_READ);

    // A full buffer wraps to position 0 and drops back to hunting.
    assign buf_full    = (write_index_reg == dfr_pkg::IDX_W'(dfr_pkg::BUFFER_DEPTH));
    assign waddr       = buf_full ? '0 : write_index_reg[dfr_pkg::ADDR_W-1:0];
    assign wi_bump     = buf_full ? dfr_pkg::IDX_W'(1) : write_index_reg + dfr_pkg::IDX_W'(1);
    assign in_pkt_bump = buf_full ? 1'b0 : in_packet_reg;

    // With two or more bytes since the last index reset, the last pair is
    // exactly prev_byte_reg followed by this byte.
    assign pair_ok = (wi_bump >= dfr_pkg::IDX_W'(2));
    assign hdr_hit = pair_ok && (prev_byte_reg == header_first_reg)
                     && (item.rx_byte == header_second_reg);
    assign trl_hit = pair_ok && (prev_byte_reg == trailer_first_reg)
                     && (item.rx_byte == trailer_second_reg);

    assign raw_len = dfr_pkg::LEN_W'(wi_bump - dfr_pkg::IDX_W'(2));

    always_comb
    begin
        clamp_len = raw_len;
        if (clamp_len > dfr_pkg::LEN_W'(max_payload_reg))
        begin
            clamp_len = dfr_pkg::LEN_W'(max_payload_reg);
        end
        if (clamp_len > dfr_pkg::LEN_W'(255))
        begin
            clamp_len = dfr_pkg::LEN_W'(255);
        end
    end

    assign rd_in_range = (32'(item.read_index) < dfr_pkg::BUFFER_DEPTH);

    always_comb
    begin
        write_index_next = write_index_reg;
        in_packet_next   = in_packet_reg;
        s1_meta_next     = s1_meta_reg;
        s1_valid_next    = s1_valid_reg;
        out_valid_next   = out_valid_reg;

        if (rx_accept)
        begin
            write_index_next = wi_bump;
            in_packet_next   = in_pkt_bump;
            if (!in_pkt_bump)
            begin
                if (hdr_hit)
                begin
                    in_packet_next   = 1'b1;
                    write_index_next = '0;
                end
            end
            else
            begin
                // trailer takes priority over a repeated header
                if (trl_hit)
                begin
                    write_index_next = '0;
                    in_packet_next   = 1'b0;
                end
                else if (hdr_hit)
                begin
                    write_index_next = '0;
                end
            end
        end

        if (accept)
        begin
            s1_meta_next.is_read        = rd_accept && rd_in_range;
            s1_meta_next.packet_done    = rx_accept && in_pkt_bump && trl_hit;
            s1_meta_next.payload_length = (rx_accept && in_pkt_bump && trl_hit)
                                          ? clamp_len[7:0] : 8'd0;
        end

        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Each item makes one RAM access, so a write and a read never share an
    // edge and a read always sees earlier writes.
    dfr_ram #(
        .WIDTH (8),
        .DEPTH (dfr_pkg::BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (rx_accept),
        .waddr (waddr),
        .wdata (item.rx_byte),
        .re    (rd_accept),
        .raddr (dfr_pkg::ADDR_W'(item.read_index)),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg   <= dfr_pkg::RST_HEADER_FIRST;
            header_second_reg  <= dfr_pkg::RST_HEADER_SECOND;
            trailer_first_reg  <= dfr_pkg::RST_TRAILER_FIRST;
            trailer_second_reg <= dfr_pkg::RST_TRAILER_SECOND;
            max_payload_reg    <= dfr_pkg::RST_MAX_PAYLOAD;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                dfr_pkg::REG_HEADER_FIRST:   header_first_reg   <= cfg_wdata[7:0];
                dfr_pkg::REG_HEADER_SECOND:  header_second_reg  <= cfg_wdata[7:0];
                dfr_pkg::REG_TRAILER_FIRST:  trailer_first_reg  <= cfg_wdata[7:0];
                dfr_pkg::REG_TRAILER_SECOND: trailer_second_reg <= cfg_wdata[7:0];
                dfr_pkg::REG_MAX_PAYLOAD:    max_payload_reg    <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            in_packet_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            in_packet_reg   <= in_packet_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            prev_byte_reg <= item.rx_byte;
        end
        s1_meta_reg <= s1_meta_next;
        if (s1_advance && s1_valid_reg)
        begin
            out_done_reg <= s1_meta_reg.packet_done;
            out_len_reg  <= s1_meta_reg.payload_length;
            out_data_reg <= s1_meta_reg.is_read ? ram_q : 8'd0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.packet_done    = out_done_reg;
    assign result.payload_length = out_len_reg;
    assign result.read_data      = out_data_reg;

endmodule

// File: tb/two_byte_delimited_packet_deframer_tb.sv
`timescale 1ns / 100ps
// Testbench for two_byte_delimited_packet_deframer: directed framing cases, then
// random packet traffic under several framing settings, with random stalls on both channels in all but the last.
// Depends on dfr_pkg, dfr_item_if, dfr_result_if and the deframer RTL.
module two_byte_delimited_packet_deframer_tb;

    localparam int RUN_LIMIT = 400000;
    localparam int PRINT_CAP = 40;
    localparam int IDLE_PCT  = 18;
    localparam logic [dfr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic       packet_done;
        logic [7:0] payload_length;
        logic [7:0] read_data;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                           cfg_wr_en;
    logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [dfr_pkg::CFG_DATA_W-1:0] cfg_wdata;

    dfr_item_if   item_ch ();
    dfr_result_if result_ch ();

    two_byte_delimited_packet_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the deframer state
    logic [7:0]                 shadow_mem [dfr_pkg::BUFFER_DEPTH];
    bit                         mem_written [dfr_pkg::BUFFER_DEPTH];
    int                         wr_idx = 0;
    bit                         in_pkt = 1'b0;
    logic [7:0]                 hdr_first  = dfr_pkg::RST_HEADER_FIRST;
    logic [7:0]                 hdr_second = dfr_pkg::RST_HEADER_SECOND;
    logic [7:0]                 trl_first  = dfr_pkg::RST_TRAILER_FIRST;
    logic [7:0]                 trl_second = dfr_pkg::RST_TRAILER_SECOND;
    logic [dfr_pkg::MAXP_W-1:0] max_pl     = dfr_pkg::RST_MAX_PAYLOAD;

    frame_result_t pending_results [$];
    int  errors       = 0;
    int  results_seen = 0;
    int  items_sent   = 0;
    int  cycle_count  = 0;
    bit  idle_on      = 1'b1;

    function automatic bit last_pair_is(input logic [7:0] first, input logic [7:0] second);
        if (wr_idx < 2 || wr_idx > dfr_pkg::BUFFER_DEPTH)
            return 1'b0;
        return shadow_mem[wr_idx-2] == first && shadow_mem[wr_idx-1] == second;
    endfunction

    function automatic frame_result_t track_deframe(input logic act, input logic [7:0] rx,
                                                     input logic [7:0] ridx);
        frame_result_t r;
        int plen;
        r = '0;
        if (act == dfr_pkg::ACT_READ)
        begin
            if (int'(ridx) < dfr_pkg::BUFFER_DEPTH)
                r.read_data = shadow_mem[ridx];
            return r;
        end
        if (wr_idx < dfr_pkg::BUFFER_DEPTH)
        begin
            shadow_mem[wr_idx] = rx;
            mem_written[wr_idx] = 1'b1;
            wr_idx++;
        end
        else
        begin
            // buffer full: start over at 0 and drop back to hunting
            in_pkt = 1'b0;
            shadow_mem[0] = rx;
            mem_written[0] = 1'b1;
            wr_idx = 1;
        end
        if (!in_pkt)
        begin
            if (last_pair_is(hdr_first, hdr_second))
            begin
                in_pkt = 1'b1;
                wr_idx = 0;
            end
        end
        else if (last_pair_is(trl_first, trl_second))
        begin
            plen = wr_idx - 2;
            if (plen > int'(max_pl))
                plen = int'(max_pl);
            if (plen > 255)
                plen = 255;
            r.packet_done = 1'b1;
            r.payload_length = plen[7:0];
            wr_idx = 0;
            in_pkt = 1'b0;
        end
        else if (last_pair_is(hdr_first, hdr_second))
        begin
            wr_idx = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch on result %0d, %s: got %0d, want %0d",
                     results_seen, field, got, want);
    endtask

    // One item transaction; updates the shadow state once accepted.
    task automatic send_item(input logic act, input logic [7:0] rx, input logic [7:0] ridx);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.rx_byte    <= rx;
        item_ch.read_index <= ridx;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_results.push_back(track_deframe(act, rx, ridx));
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(dfr_pkg::ACT_RX, b, 8'($urandom));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_item(dfr_pkg::ACT_READ, 8'($urandom), idx);
    endtask

    function automatic logic [7:0] pick_written_index();
        int i;
        i = $urandom_range(0, dfr_pkg::BUFFER_DEPTH - 1);
        while (!mem_written[i])
            i = $urandom_range(0, dfr_pkg::BUFFER_DEPTH - 1);
        return 8'(i);
    endfunction

    // Mostly random bytes, with delimiter bytes now and then for near misses.
    function automatic logic [7:0] rand_payload_byte();
        case ($urandom_range(0, 15))
            0: return hdr_first;
            1: return hdr_second;
            2: return trl_first;
            3: return trl_second;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dfr_pkg::CFG_IDX_W-1:0] addr,
                             input logic [dfr_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            dfr_pkg::REG_HEADER_FIRST:   hdr_first  = data[7:0];
            dfr_pkg::REG_HEADER_SECOND:  hdr_second = data[7:0];
            dfr_pkg::REG_TRAILER_FIRST:  trl_first  = data[7:0];
            dfr_pkg::REG_TRAILER_SECOND: trl_second = data[7:0];
            dfr_pkg::REG_MAX_PAYLOAD:    max_pl     = data[dfr_pkg::MAXP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_framing(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] t1,
                               input logic [7:0] t2, input logic [dfr_pkg::MAXP_W-1:0] maxp);
        wait_idle();
        write_reg(dfr_pkg::REG_HEADER_FIRST, dfr_pkg::CFG_DATA_W'(h1));
        write_reg(dfr_pkg::REG_HEADER_SECOND, dfr_pkg::CFG_DATA_W'(h2));
        write_reg(dfr_pkg::REG_TRAILER_FIRST, dfr_pkg::CFG_DATA_W'(t1));
        write_reg(dfr_pkg::REG_TRAILER_SECOND, dfr_pkg::CFG_DATA_W'(t2));
        write_reg(dfr_pkg::REG_MAX_PAYLOAD, dfr_pkg::CFG_DATA_W'(maxp));
    endtask

    task automatic send_packet(input int len, input bit restart, input bit close);
        send_rx(hdr_first);
        send_rx(hdr_second);
        for (int i = 0; i < len; i++)
        begin
            if (restart && i == len / 2)
            begin
                send_rx(hdr_first);
                send_rx(hdr_second);
            end
            send_rx(rand_payload_byte());
        end
        if (close)
        begin
            send_rx(trl_first);
            send_rx(trl_second);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_default_framing();
        send_rx(8'h00);
        send_rx(8'hFF);
        send_read(8'd0);
        send_read(8'd1);
        // trailer while hunting does nothing
        send_rx(trl_first);
        send_rx(trl_second);
        send_rx(hdr_first);
        send_rx(hdr_second);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(trl_first);
        send_rx(trl_second);
        send_read(8'd1);
        // empty packet
        send_packet(0, 1'b0, 1'b1);
    endtask

    task automatic test_header_restart();
        send_rx(hdr_first);
        send_rx(hdr_second);
        send_rx(8'h05);
        send_rx(hdr_first);
        send_rx(hdr_second);
        send_rx(8'h07);
        send_rx(trl_first);
        send_rx(trl_second);
    endtask

    task automatic test_length_clamp();
        set_framing(dfr_pkg::RST_HEADER_FIRST, dfr_pkg::RST_HEADER_SECOND,
                    dfr_pkg::RST_TRAILER_FIRST, dfr_pkg::RST_TRAILER_SECOND, 9'd0);
        send_packet(3, 1'b0, 1'b1);
        wait_idle();
        write_reg(dfr_pkg::REG_MAX_PAYLOAD, 9'd1);
        // writes past the register list are dropped
        write_reg(REG_UNMAPPED, 9'h1FF);
        send_packet(4, 1'b0, 1'b1);
        wait_idle();
        write_reg(dfr_pkg::REG_MAX_PAYLOAD, 9'd256);
    endtask

    task automatic test_buffer_wrap();
        logic [7:0] b;
        // hunting with no header pair, so the index runs to the end and wraps
        for (int i = 0; i <= dfr_pkg::BUFFER_DEPTH; i++)
        begin
            b = 8'($urandom);
            while (b == hdr_first)
                b = 8'($urandom);
            send_rx(b);
        end
        send_read(8'd255);
        send_read(8'd128);
        send_read(8'd127);
        send_read(8'd0);
        send_read(8'd170);
        send_read(8'd85);
    endtask

    task automatic test_random_traffic(input int n_items);
        int stop_at;
        int kind;
        int len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 62)
            begin
                if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(200, 262);
                else
                    len = $urandom_range(0, 12);
                send_packet(len, $urandom_range(0, 19) == 0, $urandom_range(0, 9) != 0);
                repeat ($urandom_range(0, 2))
                    send_read(pick_written_index());
            end
            else if (kind < 78)
            begin
                repeat ($urandom_range(1, 4))
                    send_read(pick_written_index());
            end
            else if (kind < 94)
            begin
                repeat ($urandom_range(1, 6))
                    send_rx(rand_payload_byte());
            end
            else
            begin
                // header then junk, never closed
                send_packet($urandom_range(0, 5), 1'b0, 1'b0);
            end
        end
    endtask

    // ---------------- result checking and receiver stalls ----------------

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.packet_done !== want.packet_done)
                    report_mismatch("packet_done", result_ch.packet_done, want.packet_done);
                if (result_ch.payload_length !== want.payload_length)
                    report_mismatch("payload_length", result_ch.payload_length,
                                    want.payload_length);
                if (result_ch.read_data !== want.read_data)
                    report_mismatch("read_data", result_ch.read_data, want.read_data);
            end
        end
        result_ch.ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("** two_byte_delimited_packet_deframer: FAILED **");
            $finish;
        end
    end

    initial
    begin
        item_ch.valid      <= 1'b0;
        item_ch.action     <= dfr_pkg::ACT_RX;
        item_ch.rx_byte    <= 8'd0;
        item_ch.read_index <= 8'd0;
        cfg_wr_en          <= 1'b0;
        cfg_addr           <= dfr_pkg::REG_HEADER_FIRST;
        cfg_wdata          <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_framing();
        test_header_restart();
        test_length_clamp();
        test_buffer_wrap();

        test_random_traffic(290);
        // extreme delimiter values, small clamp
        set_framing(8'h00, 8'hFF, 8'hFF, 8'h00, 9'd1);
        test_random_traffic(290);
        // header and trailer identical: trailer wins inside a packet
        set_framing(8'hA5, 8'h5A, 8'hA5, 8'h5A, 9'($urandom_range(1, 256)));
        test_random_traffic(290);
        // no stalls on either side for a long stretch
        set_framing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    9'($urandom_range(1, 256)));
        idle_on = 1'b0;
        test_random_traffic(290);
        idle_on = 1'b1;

        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("** two_byte_delimited_packet_deframer: PASSED **");
        else
            $display("** two_byte_delimited_packet_deframer: FAILED **");
        $finish;
    end

endmodule
